// ===== design/tlc_pkg.sv =====
package tlc_pkg;

	localparam int RAM_DEPTH_DEF = 2048;
	localparam int NODE_COUNT = 256;
	localparam int ADDR_W = 11;

	localparam logic [1:0] REQ_READ = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_NODE = 2'd2;

	localparam logic [2:0] REG_STATUS = 3'd0;
	localparam logic [2:0] REG_DIAG = 3'd1;
	localparam logic [2:0] REG_ADDR_HI = 3'd2;
	localparam logic [2:0] REG_ADDR_LO = 3'd3;
	localparam logic [2:0] REG_DATA = 3'd4;
	localparam logic [2:0] REG_SUBADR = 3'd5;
	localparam logic [2:0] REG_CONFIG = 3'd6;
	localparam logic [2:0] REG_SUB = 3'd7;

	localparam logic [7:0] SUB_TENT = 8'd0;
	localparam logic [7:0] SUB_NODE = 8'd1;
	localparam logic [7:0] SUB_SETUP1 = 8'd2;
	localparam logic [7:0] SUB_NEXT = 8'd3;
	localparam logic [7:0] SUB_SETUP2 = 8'd4;

	localparam logic [2:0] CMD_TX_OFF = 3'd1;
	localparam logic [2:0] CMD_RX_OFF = 3'd2;
	localparam logic [2:0] CMD_TX_EN = 3'd3;
	localparam logic [2:0] CMD_RX_EN = 3'd4;
	localparam logic [2:0] CMD_CLR = 3'd6;

	localparam logic [7:0] STATUS_RST = 8'h91;
	localparam logic [7:0] CONFIG_RST = 8'h18;
	localparam logic [7:0] STATUS_IRQ = 8'h85;
	localparam logic [7:0] DIAG_IRQ = 8'h0a;
	localparam logic [7:0] NODE_MARK = 8'hd1;
	localparam logic [7:0] DIAG_RECON = 8'hb0;
	localparam logic [7:0] MASK_IRQ = 8'h8f;
	localparam logic [7:0] MASK_HI = 8'hc7;
	localparam logic [7:0] MASK_SETUP1 = 8'hdf;
	localparam logic [7:0] MASK_SETUP2 = 8'hbf;
	localparam logic [7:0] DIAG_IDLE = 8'h30;
	localparam logic [7:0] STATUS_TXCLR = 8'hfc;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] reg_addr;
		logic [7:0] wdata;
		logic [7:0] seen_id;
	} req_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic irq;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_EXEC, ST_LATCH, ST_NID1, ST_NSEEN, ST_SEARCH, ST_DONE
	} state_t;

endpackage

// ===== design/tlc_ram.sv =====
module tlc_ram import tlc_pkg::*; #(
	parameter int DEPTH = RAM_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [7:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/token_lan_controller_registers.sv =====
// Host register block of a token-passing LAN controller: eight byte registers
// with indirect access to the packet RAM, plus node-seen events that update the
// presence map and the next ID. Each request returns one response (read data,
// zero for writes and node-seen events, and the interrupt level afterwards).
// A register access passes through the execute and done states before its response. One that
// loads the data latch from the packet RAM, or a tentative ID write, adds a latch state
// for one registered RAM or node map read. The node map is a memory with one
// registered read. A node-seen event, or a node ID write, whose ID is not yet in the
// map sets it and scans the map one ID at a time, from the own ID upward and round
// again. One request is handled at a time. After reset the packet RAM and the node
// map are zeroed by a sweep over all RAM_DEPTH addresses before the first request
// is taken. RAM_DEPTH is a power of two, at least 512.
module token_lan_controller_registers import tlc_pkg::*; #(
	parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(RAM_DEPTH);

	state_t state_q, state_d;
	req_t it_q;
	logic [AW-1:0] clr_q;
	logic [7:0] status_q, diag_q, hi_q, lo_q, latch_q, sub_q, cfg_q;
	logic [7:0] tent_q, own_q, setup1_q, next_q, setup2_q, mask_q;
	logic tent_pres_q;
	logic [7:0] rd_q, cnt_q, sid_q;
	logic phase_q, look_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic node_mem [NODE_COUNT];
	logic nd_rd_q;
	logic nd_we, nd_wd;
	logic [7:0] nd_wa, nd_ra;

	logic ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [7:0] ram_wd, ram_rd;
	logic [ADDR_W-1:0] cur, inc, lo_addr;
	logic is_rd, is_wr, is_node;
	logic rd_inc, wr_ld, wr_nid, wr_tent;
	logic [7:0] rd_val, diag_rd, sub_rd;
	logic srch_end;
	logic [7:0] found;
	logic out_free;

	tlc_ram #(.DEPTH(RAM_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	assign cur = {hi_q[2:0], lo_q};
	assign inc = cur + ADDR_W'(1);
	assign lo_addr = {hi_q[2:0], it_q.wdata};
	assign is_rd = it_q.req_type == REQ_READ;
	assign is_wr = it_q.req_type == REQ_WRITE;
	assign is_node = it_q.req_type == REQ_NODE;
	assign rd_inc = is_rd && it_q.reg_addr == REG_DATA && hi_q[7:6] == 2'b11;
	assign wr_ld = is_wr && it_q.reg_addr == REG_ADDR_LO && hi_q[7];
	assign wr_nid = is_wr && it_q.reg_addr == REG_SUB && sub_q == SUB_NODE;
	assign wr_tent = is_wr && it_q.reg_addr == REG_SUB && sub_q == SUB_TENT;
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		unique case (sub_q)
			SUB_TENT: sub_rd = tent_q;
			SUB_NODE: sub_rd = own_q;
			SUB_SETUP1: sub_rd = setup1_q;
			SUB_NEXT: sub_rd = next_q;
			SUB_SETUP2: sub_rd = setup2_q;
			default: sub_rd = 8'hff;
		endcase
	end

	always_comb begin
		diag_rd = diag_q & DIAG_IRQ;
		if (diag_rd == diag_q) begin
			diag_rd = diag_rd | DIAG_IDLE;
			if (tent_pres_q) diag_rd = diag_rd | 8'h04;
		end
	end

	always_comb begin
		unique case (it_q.reg_addr)
			REG_STATUS: rd_val = status_q;
			REG_DIAG: rd_val = diag_q;
			REG_ADDR_HI: rd_val = hi_q;
			REG_ADDR_LO: rd_val = lo_q;
			REG_DATA: rd_val = latch_q;
			REG_SUBADR: rd_val = sub_q;
			REG_CONFIG: rd_val = cfg_q;
			default: rd_val = sub_rd;
		endcase
	end

	// look_q high: nd_rd_q holds the map bit of cnt_q
	always_comb begin
		srch_end = 1'b0;
		found = 8'd0;
		if (look_q) begin
			if (nd_rd_q) begin
				srch_end = 1'b1;
				found = cnt_q;
			end else if (!phase_q) begin
				srch_end = cnt_q == 8'hff && own_q == 8'd0;
			end else begin
				srch_end = cnt_q == own_q;
			end
		end
	end

	always_comb begin
		nd_we = 1'b0;
		nd_wa = sid_q;
		nd_wd = 1'b1;
		nd_ra = sid_q;
		unique case (state_q)
			ST_CLEAR: begin
				nd_we = 1'b1;
				nd_wa = clr_q[7:0];
				nd_wd = 1'b0;
			end
			ST_EXEC: nd_ra = is_node ? it_q.seen_id : it_q.wdata;
			ST_NSEEN: nd_we = !nd_rd_q;
			ST_SEARCH: nd_ra = cnt_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (nd_we) node_mem[nd_wa] <= nd_wd;
		nd_rd_q <= node_mem[nd_ra];
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = cur[AW-1:0];
		ram_wd = it_q.wdata;
		ram_ra = cur[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_wa = clr_q;
				ram_wd = 8'd0;
			end
			ST_EXEC: begin
				if (rd_inc) ram_ra = inc[AW-1:0];
				if (wr_ld) ram_ra = lo_addr[AW-1:0];
				if (is_wr && it_q.reg_addr == REG_DATA && !hi_q[7]) ram_we = 1'b1;
				if (wr_nid) begin
					ram_we = 1'b1;
					ram_wa = '0;
					ram_wd = NODE_MARK;
				end
			end
			ST_NID1: begin
				ram_we = 1'b1;
				ram_wa = AW'(1);
				ram_wd = own_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == AW'(RAM_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: if (req_valid) state_d = ST_EXEC;
			ST_EXEC: begin
				priority if (rd_inc || wr_ld || wr_tent) state_d = ST_LATCH;
				else if (wr_nid) state_d = ST_NID1;
				else if (is_node) state_d = ST_NSEEN;
				else state_d = ST_DONE;
			end
			ST_LATCH: state_d = ST_DONE;
			ST_NID1: state_d = ST_NSEEN;
			ST_NSEEN: state_d = nd_rd_q ? ST_DONE : ST_SEARCH;
			ST_SEARCH: if (srch_end) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) it_q <= req;
		if (state_q == ST_EXEC) begin
			rd_q <= is_rd ? rd_val : 8'd0;
			sid_q <= is_node ? it_q.seen_id : it_q.wdata;
		end
		if (state_q == ST_NSEEN) begin
			cnt_q <= own_q;
			phase_q <= 1'b0;
			look_q <= 1'b0;
		end
		if (state_q == ST_SEARCH) begin
			look_q <= !look_q;
			if (look_q && !nd_rd_q) begin
				if (!phase_q && cnt_q == 8'hff) begin
					phase_q <= 1'b1;
					cnt_q <= 8'd1;
				end else begin
					cnt_q <= cnt_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			status_q <= STATUS_RST;
			diag_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			latch_q <= '0;
			sub_q <= '0;
			cfg_q <= CONFIG_RST;
			tent_q <= '0;
			own_q <= '0;
			setup1_q <= '0;
			next_q <= '0;
			setup2_q <= '0;
			mask_q <= '0;
			tent_pres_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != ST_DONE) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_EXEC: begin
					if (is_rd) begin
						if (it_q.reg_addr == REG_DIAG) diag_q <= diag_rd;
						if (it_q.reg_addr == REG_SUB && sub_q == SUB_NEXT)
							diag_q <= diag_q & 8'hfd;
						if (rd_inc) {hi_q[2:0], lo_q} <= inc;
					end else if (is_wr) begin
						unique case (it_q.reg_addr)
							REG_STATUS: mask_q <= it_q.wdata & MASK_IRQ;
							REG_DIAG: begin
								unique case (it_q.wdata[2:0])
									CMD_TX_OFF: status_q <= status_q | 8'h01;
									CMD_TX_EN: status_q <= status_q & STATUS_TXCLR;
									CMD_RX_EN: status_q <= status_q & 8'h7f;
									CMD_CLR: begin
										status_q <= status_q
											& ~{3'd0, it_q.wdata[4], 1'b0, it_q.wdata[2], 2'd0};
										if (it_q.wdata[4]) diag_q <= diag_q & 8'hf7;
									end
									default: begin
									end
								endcase
							end
							REG_ADDR_HI: hi_q <= it_q.wdata & MASK_HI;
							REG_ADDR_LO: lo_q <= it_q.wdata;
							REG_DATA: begin
								latch_q <= it_q.wdata;
								if (!hi_q[7] && hi_q[6]) {hi_q[2:0], lo_q} <= inc;
							end
							REG_SUBADR: begin
								sub_q <= it_q.wdata & MASK_IRQ;
								cfg_q <= {cfg_q[7:2], it_q.wdata[1:0]};
							end
							REG_CONFIG: begin
								cfg_q <= it_q.wdata;
								sub_q <= {6'd0, it_q.wdata[1:0]};
							end
							default: begin
								unique case (sub_q)
									SUB_TENT: tent_q <= it_q.wdata;
									SUB_NODE: begin
										own_q <= it_q.wdata;
										status_q <= status_q | 8'h04;
										diag_q <= DIAG_RECON;
									end
									SUB_SETUP1: setup1_q <= it_q.wdata & MASK_SETUP1;
									SUB_SETUP2: setup2_q <= it_q.wdata & MASK_SETUP2;
									default: begin
									end
								endcase
							end
						endcase
					end
				end
				ST_LATCH: begin
					if (wr_tent) begin
						diag_q <= {diag_q[7:3], nd_rd_q, diag_q[1:0]};
						tent_pres_q <= nd_rd_q;
					end else begin
						latch_q <= ram_rd;
					end
				end
				ST_NSEEN: begin
					if (!nd_rd_q && tent_q == sid_q) begin
						diag_q <= diag_q | 8'h04;
						tent_pres_q <= 1'b1;
					end
				end
				ST_SEARCH: begin
					if (srch_end && next_q != found) begin
						next_q <= found;
						diag_q <= diag_q | 8'h02;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q.rdata <= rd_q;
						rsp_q.irq <= |(((status_q & STATUS_IRQ) | (diag_q & DIAG_IRQ)) & mask_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTH
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == ST_EXEC)
		else $error("accepted request did not start execution");
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside completion");
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_CLEAR |=> state_q != ST_CLEAR)
		else $error("RAM clear re-entered");
	a_wrap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH && phase_q |-> cnt_q != 8'd0)
		else $error("second search pass reached id zero");
`endif

endmodule
